FILE: sv/clc_pkg.sv
// clc_pkg: modes, status codes and shared types of the circular list block
// no dependencies
`default_nettype none
package clc_pkg;
    typedef enum logic [2:0] {
        M_INSERT = 3'd0, M_GET = 3'd1, M_DEL_AT = 3'd2, M_DEL_HANDLE = 3'd3,
        M_RESET = 3'd4, M_NEXT = 3'd5, M_CLEAR = 3'd6, M_NOP = 3'd7
    } t_mode;
    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_NOTFOUND = 2'd3
    } t_status;
endpackage
`default_nettype wire

FILE: sv/clc_ram.sv
// clc_ram: generic single-port write, single-port read RAM, registered read
// no dependencies
`default_nettype none
module clc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/circular_list_with_cursor_top.sv
// circular_list_with_cursor_top: circular list of handles with a cursor
// depends on clc_pkg and clc_ram
//
//  channel | signals                                  | direction
//  request | i_valid/o_ready, mode, position, handle  | in
//  result  | o_valid/i_ready, status, handles, count  | out
//
// entries live in one RAM; a request is served by a sequencer, result registered
// reset/next: read the entry, then the cursor; get: first subtract count until the position fits
// insert: one RAM read and write per shifted entry
// delete-at: read then shift; delete-handle: search, then read and shift
// one request at a time, ready again in the same cycle as its result appears; a new
// request is taken while a result waits, and its own result stalls until that one leaves
`default_nettype none
module circular_list_with_cursor_top
    import clc_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_mode,
    input  wire logic [7:0]  i_position,
    input  wire logic [31:0] i_item_handle,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_result_handle,
    output logic [4:0]       o_element_count,
    output logic             o_cursor_valid,
    output logic [31:0]      o_cursor_handle
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_MOD, S_READ, S_READW, S_SEARCH, S_SHIFT,
        S_CREAD, S_CWAIT, S_DONE
    } t_state;

    t_state       r_state;
    t_mode        r_mode;
    logic [PW-1:0] r_pos;
    logic [31:0]  r_handle;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_cidx;
    logic         r_cpres;
    logic [AW-1:0] r_k;
    logic [CW-1:0] r_shift;
    logic [1:0]   r_status;
    logic [31:0]  r_res;
    logic         r_busy;
    logic         r_rd_pend;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;

    clc_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [CW-1:0] cpos;
    logic          cnt_zero;
    logic          out_free;
    assign cpos     = ({1'b0, r_cidx} < {1'b0, r_count}) ? CW'(r_cidx) : '0;
    assign cnt_zero = (r_count == '0);
    assign out_free = !o_valid || i_ready;
    assign o_ready  = !r_busy;

    // combinational RAM control
    always_comb begin
        we    = 1'b0;
        waddr = r_k;
        wdata = rdata;
        raddr = r_k;
        case (r_state)
            S_SHIFT: begin
                // the entry from the registered RAM read moves one place
                if (r_rd_pend) begin
                    we = 1'b1;
                    if (r_mode == M_INSERT) begin
                        waddr = AW'(r_k + 2'd2);
                    end else begin
                        waddr = AW'(r_k - 2'd2);
                    end
                end
                if (r_mode == M_INSERT && r_shift == '0 && !r_rd_pend) begin
                    we    = 1'b1;
                    waddr = AW'(r_pos);
                    wdata = r_handle;
                end
            end
            S_CREAD, S_CWAIT: raddr = AW'(cpos);
            default: raddr = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            o_valid   <= 1'b0;
            r_count   <= '0;
            r_cidx    <= '0;
            r_cpres   <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_CWAIT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode   <= t_mode'(i_mode);
                        r_pos    <= PW'(i_position);
                        r_handle <= i_item_handle;
                        r_busy   <= 1'b1;
                        r_state  <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_res     <= '0;
                    r_rd_pend <= 1'b0;
                    case (r_mode)
                        M_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_CREAD;
                            end else begin
                                r_status <= ST_OK;
                                if (r_pos > PW'(r_count)) r_pos <= PW'(r_count);
                                r_shift <= r_count - ((r_pos > PW'(r_count)) ?
                                           r_count : CW'(r_pos));
                                r_k     <= AW'(r_count - 1'b1);
                                r_state <= S_SHIFT;
                            end
                        end
                        M_GET, M_DEL_AT, M_RESET, M_NEXT, M_DEL_HANDLE: begin
                            if (cnt_zero) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_CREAD;
                            end else begin
                                r_status <= ST_OK;
                                case (r_mode)
                                    M_GET:   r_state <= S_MOD;
                                    M_RESET: begin
                                        r_pos   <= '0;
                                        r_k     <= '0;
                                        r_state <= S_READ;
                                    end
                                    M_NEXT: begin
                                        r_pos   <= PW'(cpos);
                                        r_k     <= AW'(cpos);
                                        r_state <= S_READ;
                                    end
                                    M_DEL_AT: begin
                                        if (r_pos >= PW'(r_count)) begin
                                            r_pos <= PW'(r_count - 1'b1);
                                            r_k   <= AW'(r_count - 1'b1);
                                        end else begin
                                            r_k <= AW'(r_pos);
                                        end
                                        r_state <= S_READ;
                                    end
                                    default: begin
                                        r_k     <= '0;
                                        r_state <= S_SEARCH;
                                    end
                                endcase
                            end
                        end
                        M_CLEAR: begin
                            r_status <= ST_OK;
                            r_count  <= '0;
                            r_cidx   <= '0;
                            r_cpres  <= 1'b0;
                            r_state  <= S_CREAD;
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_state  <= S_CREAD;
                        end
                    endcase
                end
                S_MOD: begin
                    if (r_pos >= PW'(r_count)) begin
                        r_pos <= r_pos - PW'(r_count);
                    end else begin
                        r_k     <= AW'(r_pos);
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_READW;
                S_READW: begin
                    r_res <= rdata;
                    case (r_mode)
                        M_GET, M_RESET: begin
                            r_cidx  <= AW'(r_pos);
                            r_cpres <= 1'b1;
                            r_state <= S_CREAD;
                        end
                        M_NEXT: begin
                            r_cidx  <= (r_pos + 1'b1 < PW'(r_count)) ?
                                       AW'(r_pos + 1'b1) : '0;
                            r_cpres <= 1'b1;
                            r_state <= S_CREAD;
                        end
                        default: begin
                            // delete: shift followers down one place
                            r_shift   <= r_count - CW'(r_pos) - 1'b1;
                            r_k       <= AW'(r_pos + 1'b1);
                            r_rd_pend <= 1'b0;
                            r_state   <= S_SHIFT;
                        end
                    endcase
                end
                S_SEARCH: begin
                    if (r_rd_pend) begin
                        if (rdata == r_handle) begin
                            r_pos   <= PW'(AW'(r_k - 1'b1));
                            r_k     <= AW'(r_k - 1'b1);
                            r_rd_pend <= 1'b0;
                            r_state <= S_READ;
                        end else if (CW'(AW'(r_k - 1'b1)) == r_count - 1'b1) begin
                            r_status <= ST_NOTFOUND;
                            r_rd_pend <= 1'b0;
                            r_state  <= S_CREAD;
                        end else begin
                            r_k <= AW'(r_k + 1'b1);
                        end
                    end else begin
                        r_rd_pend <= 1'b1;
                        r_k       <= AW'(r_k + 1'b1);
                    end
                end
                S_SHIFT: begin
                    if (r_mode == M_INSERT) begin
                        if (r_shift != '0) begin
                            r_rd_pend <= 1'b1;
                            r_shift   <= r_shift - 1'b1;
                            r_k       <= AW'(r_k - 1'b1);
                        end else if (r_rd_pend) begin
                            r_rd_pend <= 1'b0;
                        end else begin
                            r_count   <= r_count + 1'b1;
                            r_cidx    <= AW'(r_pos);
                            r_cpres   <= 1'b1;
                            r_state   <= S_CREAD;
                        end
                    end else begin
                        if (r_shift == '0) begin
                            r_rd_pend <= 1'b0;
                            r_count   <= r_count - 1'b1;
                            if (r_count == CW'(1)) begin
                                r_cpres <= 1'b0;
                                r_cidx  <= '0;
                            end else if (r_mode == M_DEL_AT || !r_cpres ||
                                         cpos == CW'(r_pos)) begin
                                r_cpres <= 1'b1;
                                r_cidx  <= (CW'(r_pos) < r_count - 1'b1) ?
                                           AW'(r_pos) : '0;
                            end else begin
                                r_cidx <= (cpos > CW'(r_pos)) ?
                                          AW'(cpos - 1'b1) : AW'(cpos);
                            end
                            r_state <= S_CREAD;
                        end else begin
                            r_rd_pend <= 1'b1;
                            r_shift   <= r_shift - 1'b1;
                            r_k       <= AW'(r_k + 1'b1);
                        end
                    end
                end
                S_CREAD: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (out_free) begin
                        o_valid         <= 1'b1;
                        o_status        <= r_status;
                        o_result_handle <= (r_status == ST_OK) ? r_res : '0;
                        o_element_count <= 5'(r_count);
                        o_cursor_valid  <= r_cpres && !cnt_zero;
                        o_cursor_handle <= (r_cpres && !cnt_zero) ? rdata : '0;
                        r_busy          <= 1'b0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // count never passes capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_busy)
        else $error("busy while idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_valid) |-> (o_cursor_valid == (o_element_count != 5'd0)))
        else $error("cursor and count disagree");
endmodule
`default_nettype wire
